[rtl/memory_access_watchpoint_checker_defines.svh]
// Assertion macros shared by the watchpoint checker RTL.
// Depends on nothing; the including module must have clk and arst_n in scope.
`ifndef MEMORY_ACCESS_WATCHPOINT_CHECKER_DEFINES_SVH
`define MEMORY_ACCESS_WATCHPOINT_CHECKER_DEFINES_SVH

// Implication checked at every clock edge outside reset
`define MAWC_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition that must never hold outside reset
`define MAWC_ASSERT_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

[rtl/mawc_pkg.sv]
// Types, codes and helpers for the memory access watchpoint checker.
// Used by mawc_cell and memory_access_watchpoint_checker; no dependencies.
package mawc_pkg;

	localparam int WATCH_ENTRIES_DEF = 16;
	// probe hit count wide enough for the largest supported table (256)
	localparam int CNT_W = 9;

	localparam logic [1:0] CMD_ACCESS = 2'd0;
	localparam logic [1:0] CMD_SET    = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;
	localparam logic [1:0] CMD_POLL   = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_BERR = 2'd1;
	localparam logic [1:0] ST_BP   = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	localparam logic [1:0] ACC_READ  = 2'b01;
	localparam logic [1:0] ACC_WRITE = 2'b10;

	localparam logic [2:0] EK_READ  = 3'b001;
	localparam logic [2:0] EK_WRITE = 3'b010;
	localparam logic [2:0] EK_RW    = 3'b011;
	localparam logic [2:0] EK_BREAK = 3'b101;

	// config register indexes
	localparam logic [2:0] REG_R0_BASE = 3'd0;
	localparam logic [2:0] REG_R0_SIZE = 3'd1;
	localparam logic [2:0] REG_R0_RO   = 3'd2;
	localparam logic [2:0] REG_R1_BASE = 3'd3;
	localparam logic [2:0] REG_R1_SIZE = 3'd4;
	localparam logic [2:0] REG_R1_RO   = 3'd5;

	typedef struct packed {
		logic [31:0] start;
		logic [32:0] end_a;
		logic [2:0]  kind;
		logic        region;
	} entry_t;

	// access walking down the cell chain
	typedef struct packed {
		logic             active;
		logic [31:0]      addr;
		logic [32:0]      end_a;
		logic             span2;
		logic [1:0]       acc;
		logic             region;
		logic             alive;
		logic             bp;
		logic [CNT_W-1:0] cnt;
	} probe_t;

	typedef struct packed {
		logic ins_en;
		logic del_en;
	} cell_ctrl_t;

	function automatic logic [2:0] kind_bits(input logic [1:0] k);
		logic [2:0] r;
		case (k)
			2'd0:    r = EK_READ;
			2'd1:    r = EK_WRITE;
			2'd2:    r = EK_RW;
			default: r = EK_BREAK;
		endcase
		return r;
	endfunction

endpackage

[rtl/memory_access_watchpoint_checker.sv]
// Memory access watchpoint checker: one transaction at a time. Set, clear, poll
// and any transaction that ends in a bus error pass through the execute state to
// the result register; an access checked against the table also passes the scan
// state, as its probe walks the cell chain one cell per clock. The input is
// taken again as soon as the result sits in the output register; while an
// earlier result still waits there, a finished one holds and the input stays
// closed. Depends on mawc_pkg, mawc_cell and the defines header.
`include "memory_access_watchpoint_checker_defines.svh"

module memory_access_watchpoint_checker #(
	parameter int WATCH_ENTRIES = mawc_pkg::WATCH_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // cmd[1:0], address[33:2], span[65:34], zero pad
	input  logic [1:0]  s_tuser,  // kind[1:0]
	// master stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // status[1:0], region_index[2], region_offset[34:3],
	                              // hit_count[66:35], zero pad
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int USED_W = $clog2(WATCH_ENTRIES + 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_SCAN = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q;

	// config registers
	logic [31:0] r0_base_q, r0_size_q, r1_base_q, r1_size_q;
	logic        r0_ro_q, r1_ro_q;
	logic        cfg_wr;
	logic [2:0]  cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r0_base_q <= '0;
			r0_size_q <= '0;
			r0_ro_q   <= 1'b0;
			r1_base_q <= '0;
			r1_size_q <= '0;
			r1_ro_q   <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				mawc_pkg::REG_R0_BASE: r0_base_q <= pwdata;
				mawc_pkg::REG_R0_SIZE: r0_size_q <= pwdata;
				mawc_pkg::REG_R0_RO:   r0_ro_q   <= pwdata[0];
				mawc_pkg::REG_R1_BASE: r1_base_q <= pwdata;
				mawc_pkg::REG_R1_SIZE: r1_size_q <= pwdata;
				mawc_pkg::REG_R1_RO:   r1_ro_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			mawc_pkg::REG_R0_BASE: prdata = r0_base_q;
			mawc_pkg::REG_R0_SIZE: prdata = r0_size_q;
			mawc_pkg::REG_R0_RO:   prdata = {31'd0, r0_ro_q};
			mawc_pkg::REG_R1_BASE: prdata = r1_base_q;
			mawc_pkg::REG_R1_SIZE: prdata = r1_size_q;
			mawc_pkg::REG_R1_RO:   prdata = {31'd0, r1_ro_q};
			default:               prdata = '0;
		endcase
	end

	// captured transaction
	logic [1:0]  cmd_q;
	logic [31:0] addr_q;
	logic [31:0] span_q;
	logic [1:0]  kind_q;
	logic        in_acc;

	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q  <= s_tdata[1:0];
			addr_q <= s_tdata[33:2];
			span_q <= s_tdata[65:34];
			kind_q <= s_tuser;
		end
	end

	// region match
	logic [32:0] end_a;
	logic        r0_hit, r1_hit, region_ok, rsel;
	logic [31:0] roff;

	assign end_a  = {1'b0, addr_q} + {1'b0, span_q};
	assign r0_hit = (r0_size_q != '0) && (addr_q >= r0_base_q) &&
	                (end_a <= ({1'b0, r0_base_q} + {1'b0, r0_size_q}));
	assign r1_hit = (r1_size_q != '0) && (addr_q >= r1_base_q) &&
	                (end_a <= ({1'b0, r1_base_q} + {1'b0, r1_size_q}));
	assign region_ok = r0_hit || r1_hit;
	assign rsel      = !r0_hit;
	assign roff      = addr_q - (rsel ? r1_base_q : r0_base_q);

	// cell chain
	logic [USED_W-1:0]    used_q;
	logic [31:0]          hit_q;
	logic                 full;
	logic                 any_match;
	logic                 exec;
	mawc_pkg::entry_t     new_entry;
	mawc_pkg::cell_ctrl_t ctrl;
	mawc_pkg::probe_t     launch;

	mawc_pkg::entry_t entry_w  [WATCH_ENTRIES];
	mawc_pkg::entry_t prev_w   [WATCH_ENTRIES];
	mawc_pkg::entry_t next_w   [WATCH_ENTRIES];
	mawc_pkg::probe_t pin_w    [WATCH_ENTRIES];
	mawc_pkg::probe_t pout_w   [WATCH_ENTRIES];
	logic [WATCH_ENTRIES-1:0] ins_w, insp_w, match_w, del_w, delp_w, valid_w;

	assign exec      = (state_q == S_EXEC);
	assign full      = (used_q == USED_W'(WATCH_ENTRIES));
	assign any_match = |match_w;
	assign new_entry = '{start: addr_q, end_a: end_a,
	                     kind: mawc_pkg::kind_bits(kind_q), region: rsel};

	assign ctrl.ins_en = exec && (cmd_q == mawc_pkg::CMD_SET) && region_ok &&
	                     !any_match && !full;
	assign ctrl.del_en = exec && (cmd_q == mawc_pkg::CMD_CLEAR) && region_ok;

	always_comb begin
		launch        = '0;
		launch.active = exec && (cmd_q == mawc_pkg::CMD_ACCESS) && region_ok &&
		                !(kind_q[0] && (rsel ? r1_ro_q : r0_ro_q));
		launch.addr   = addr_q;
		launch.end_a  = end_a;
		launch.span2  = (span_q == 32'd2);
		launch.acc    = kind_q[0] ? mawc_pkg::ACC_WRITE : mawc_pkg::ACC_READ;
		launch.region = rsel;
		launch.alive  = 1'b1;
	end

	genvar gi;
	generate
		for (gi = 0; gi < WATCH_ENTRIES; gi++) begin : g_cell
			assign valid_w[gi] = (used_q > USED_W'(gi));
			if (gi == 0) begin : g_head
				assign prev_w[gi] = new_entry;
				assign insp_w[gi] = 1'b0;
				assign delp_w[gi] = 1'b0;
				assign pin_w[gi]  = launch;
			end else begin : g_body
				assign prev_w[gi] = entry_w[gi-1];
				assign insp_w[gi] = ins_w[gi-1];
				assign delp_w[gi] = del_w[gi-1];
				assign pin_w[gi]  = pout_w[gi-1];
			end
			if (gi == WATCH_ENTRIES - 1) begin : g_tail
				assign next_w[gi] = entry_w[gi];
			end else begin : g_mid
				assign next_w[gi] = entry_w[gi+1];
			end

			mawc_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.valid      (valid_w[gi]),
				.new_entry  (new_entry),
				.prev_entry (prev_w[gi]),
				.next_entry (next_w[gi]),
				.ctrl       (ctrl),
				.ins_prev   (insp_w[gi]),
				.del_prev   (delp_w[gi]),
				.probe_in   (pin_w[gi]),
				.entry      (entry_w[gi]),
				.ins_here   (ins_w[gi]),
				.match      (match_w[gi]),
				.del_out    (del_w[gi]),
				.probe_out  (pout_w[gi])
			);
		end
	endgenerate

	// chain output and saturating hit update
	mawc_pkg::probe_t tail;
	logic [32:0]      hit_sum;
	logic             scan_done;

	assign tail      = pout_w[WATCH_ENTRIES-1];
	assign scan_done = (state_q == S_SCAN) && tail.active;
	assign hit_sum   = {1'b0, hit_q} + 33'(tail.cnt);

	// result holding and control
	logic [1:0]  res_status_q;
	logic        res_ridx_q;
	logic [31:0] res_roff_q;
	logic [31:0] res_hits_q;
	logic [1:0]  out_status_q;
	logic        out_ridx_q;
	logic [31:0] out_roff_q;
	logic [31:0] out_hits_q;
	logic        done_go;

	assign done_go = (state_q == S_DONE) && (!m_tvalid || m_tready);

	always_ff @(posedge clk) begin
		if (exec) begin
			res_hits_q   <= '0;
			res_ridx_q   <= 1'b0;
			res_roff_q   <= '0;
			res_status_q <= mawc_pkg::ST_OK;
			if (cmd_q == mawc_pkg::CMD_POLL) begin
				res_hits_q <= hit_q;
			end else if (!region_ok) begin
				res_status_q <= mawc_pkg::ST_BERR;
			end else if ((cmd_q == mawc_pkg::CMD_ACCESS) && !launch.active) begin
				res_status_q <= mawc_pkg::ST_BERR;
			end else if ((cmd_q == mawc_pkg::CMD_SET) && !any_match && full) begin
				res_status_q <= mawc_pkg::ST_FULL;
			end else begin
				res_ridx_q <= rsel;
				res_roff_q <= roff;
			end
		end else if (scan_done && tail.bp) begin
			res_status_q <= mawc_pkg::ST_BP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			used_q   <= '0;
			hit_q    <= '0;
			m_tvalid <= 1'b0;
		end else begin
			// output valid: raised when a result loads, dropped when taken
			if (done_go) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (cmd_q == mawc_pkg::CMD_POLL) begin
						hit_q <= '0;
					end
					if (ctrl.ins_en) begin
						used_q <= used_q + USED_W'(1);
					end else if (ctrl.del_en && any_match) begin
						used_q <= used_q - USED_W'(1);
					end
					state_q <= launch.active ? S_SCAN : S_DONE;
				end
				S_SCAN: begin
					if (tail.active) begin
						hit_q   <= hit_sum[32] ? 32'hFFFF_FFFF : hit_sum[31:0];
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (done_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (done_go) begin
			out_status_q <= res_status_q;
			out_ridx_q   <= res_ridx_q;
			out_roff_q   <= res_roff_q;
			out_hits_q   <= res_hits_q;
		end
	end

	assign m_tdata = {5'd0, out_hits_q, out_roff_q, out_ridx_q, out_status_q};

	// checks
	`MAWC_ASSERT_IMP(a_used_bound, 1'b1, (used_q <= USED_W'(WATCH_ENTRIES)), "fill count past table depth")
	`MAWC_ASSERT_IMP(a_ins_not_full, ctrl.ins_en, (!full && !ctrl.del_en), "insert into full table")
	`MAWC_ASSERT_IMP(a_probe_in_scan, tail.active, (state_q == S_SCAN), "probe left chain outside scan")
	`MAWC_ASSERT_NEVER(a_match_unique, (!$onehot0(match_w)), "duplicate exact entries in table")

endmodule

[rtl/mawc_cell.sv]
// One watch table cell: holds an entry, shifts it for sorted insert and delete,
// and checks the passing access probe. Depends on mawc_pkg.
module mawc_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid,
	input  mawc_pkg::entry_t    new_entry,
	input  mawc_pkg::entry_t    prev_entry,
	input  mawc_pkg::entry_t    next_entry,
	input  mawc_pkg::cell_ctrl_t ctrl,
	input  logic                ins_prev,
	input  logic                del_prev,
	input  mawc_pkg::probe_t    probe_in,
	output mawc_pkg::entry_t    entry,
	output logic                ins_here,
	output logic                match,
	output logic                del_out,
	output mawc_pkg::probe_t    probe_out
);

	mawc_pkg::entry_t entry_q;
	mawc_pkg::probe_t probe_q;
	mawc_pkg::probe_t probe_d;
	logic             in_rng;

	assign entry    = entry_q;
	assign probe_out = probe_q;

	// invalid cells sit past the end, so this flag is monotone along the chain
	assign ins_here = !valid || (entry_q.start > new_entry.start);
	assign match    = valid && (entry_q == new_entry);
	assign del_out  = del_prev || match;

	// entry storage: insert or delete shift
	always_ff @(posedge clk) begin
		if (ctrl.ins_en && ins_here) begin
			entry_q <= ins_prev ? prev_entry : new_entry;
		end else if (ctrl.del_en && del_out) begin
			entry_q <= next_entry;
		end
	end

	// probe check against this entry
	assign in_rng = (probe_in.addr >= entry_q.start) && (probe_in.end_a <= entry_q.end_a);

	always_comb begin
		probe_d = probe_in;
		if (probe_in.active && probe_in.alive && valid &&
		    (entry_q.region == probe_in.region) &&
		    ((entry_q.kind[1:0] & probe_in.acc) != 2'b00)) begin
			if (entry_q.kind[2]) begin
				if (probe_in.span2 && in_rng) begin
					probe_d.bp    = 1'b1;
					probe_d.alive = 1'b0;
				end
			end else if (in_rng) begin
				probe_d.cnt = probe_in.cnt + {{(mawc_pkg::CNT_W-1){1'b0}}, 1'b1};
			end else if (entry_q.start > probe_in.addr) begin
				probe_d.alive = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= '0;
		end else begin
			probe_q <= probe_d;
		end
	end

endmodule
